[sv/slra_pkg.sv]
// Shared types and constants of the slot reuse label allocator.
// Item field widths, stream packing, codes and the delete-map control struct.
// No dependencies.
`timescale 1ns / 1ps

package slra_pkg;

	// result field widths as seen on the stream
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 10;
	localparam int LABEL_W   = 12;
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 32;
	localparam int M_PAD_W   = M_TDATA_W - STATUS_W - SLOT_W - LABEL_W - 1;

	// delete map row: one memory word covers this many slots
	localparam int ROW_BITS = 32;
	localparam int BIT_W    = 5;

	typedef enum logic {
		KIND_ADD = 1'b0,
		KIND_DEL = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOLABEL  = 2'd2,
		ST_BADLABEL = 2'd3
	} status_t;

	// delete map access strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} dm_ctl_t;

endpackage

[sv/slot_reuse_label_allocator_unit.sv]
// Slot allocator with label remapping for a flat vector store.
// Input stream (s_*): tuser carries the kind (add or delete), tdata the label to delete.
// Output stream (m_*): one result item per input item, carrying status, slot, the new
// label and the reused flag; the slot tells outside memory which row to write.
// Items are handled one at a time; s_tready is high while the sequencer is idle.
// The steps from acceptance to the result register follow the read-modify-write
// chain through the table RAMs, whose reads are registered:
//   add appending at the next unused slot, or add refused: no table read first
//   add reusing the lowest deleted slot: bitmap row read, slot label read,
//     old label invalidate, new label write
//   delete: label table read, bitmap row read and update
// The next item is taken only after the sequencer has returned to idle.
// The result waits in a single output register; while the receiver stalls, one
// more item is taken and held in its final step, and the input stalls until the
// register drains.
// Reset clears the counters and the deleted-slot summary bits at once; the label
// table is qualified by the label counter, so no clearing pass is needed.
// Depends on slra_pkg, slra_ram and slra_delmap.
`timescale 1ns / 1ps

module slot_reuse_label_allocator_unit #(
	parameter int SLOTS  = 1024,
	parameter int LABELS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [11:0] del_label
	input  logic [slra_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] kind
	input  logic [slra_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] status, [11:2] slot, [23:12] new_label, [24] reused
	output logic [slra_pkg::M_TDATA_W-1:0] m_tdata
);

	import slra_pkg::*;

	localparam int NROWS = (SLOTS + ROW_BITS - 1) / ROW_BITS;
	localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int SXW   = RW + BIT_W;
	localparam int SAW   = $clog2(SLOTS);
	localparam int UW    = $clog2(SLOTS + 1);
	localparam int LW    = $clog2(LABELS);
	localparam int NW    = $clog2(LABELS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_A1, S_A2, S_A3, S_A4, S_D1, S_D2, S_D3
	} state_t;

	state_t             state_q;
	logic [LABEL_W-1:0] label_q;
	logic [RW-1:0]      row_q;
	logic [SXW-1:0]     pick_q;
	logic [UW-1:0]      used_q;
	logic [NW-1:0]      next_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// table ports
	logic           sl_we, sl_re;
	logic [SAW-1:0] sl_waddr, sl_raddr;
	logic [LW-1:0]  sl_wdata, sl_rdata;
	logic           ls_we, ls_re;
	logic [LW-1:0]  ls_waddr, ls_raddr;
	logic [SXW:0]   ls_wdata, ls_rdata;

	// delete map ports
	dm_ctl_t             dm_ctl;
	logic [RW-1:0]       dm_rd_row, dm_wr_row, dm_low_row;
	logic [ROW_BITS-1:0] dm_wr_bits, dm_rd_word;
	logic                dm_any;
	logic [BIT_W-1:0]    dm_low_bit;

	// sequencing terms
	logic           out_free;
	logic           out_load;
	logic           full;
	logic           no_label;
	logic           bad_label;
	logic [SXW-1:0] reuse_pick;
	logic [SXW-1:0] del_slot;
	logic [BIT_W-1:0] del_bit;

	assign out_free   = !m_tvalid_q || m_tready;
	assign full       = !dm_any && (used_q == UW'(SLOTS));
	assign no_label   = (next_q == NW'(LABELS));
	assign bad_label  = (32'(label_q) >= 32'(LABELS)) || (32'(label_q) >= 32'(next_q));
	assign reuse_pick = {row_q, dm_low_bit};
	assign del_slot   = ls_rdata[SXW-1:0];
	assign del_bit    = pick_q[BIT_W-1:0];

	// a result is written into the output register in this cycle
	assign out_load = out_free && (
		((state_q == S_A1) && (full || no_label || !dm_any)) ||
		(state_q == S_A4) ||
		((state_q == S_D1) && bad_label) ||
		((state_q == S_D2) && !ls_rdata[SXW]) ||
		(state_q == S_D3));

	slra_ram #(
		.W (LW),
		.D (SLOTS)
	) u_slot_label (
		.clk   (clk),
		.we    (sl_we),
		.waddr (sl_waddr),
		.wdata (sl_wdata),
		.re    (sl_re),
		.raddr (sl_raddr),
		.rdata (sl_rdata)
	);

	// entry: {live, slot}
	slra_ram #(
		.W (SXW + 1),
		.D (LABELS)
	) u_label_slot (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (ls_wdata),
		.re    (ls_re),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	slra_delmap #(
		.ROWS (NROWS),
		.RW   (RW)
	) u_delmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (dm_ctl),
		.rd_row  (dm_rd_row),
		.wr_row  (dm_wr_row),
		.wr_bits (dm_wr_bits),
		.any     (dm_any),
		.low_row (dm_low_row),
		.rd_word (dm_rd_word),
		.low_bit (dm_low_bit)
	);

	// drive table accesses for the current step
	always_comb begin
		sl_we      = 1'b0;
		sl_waddr   = '0;
		sl_wdata   = '0;
		sl_re      = 1'b0;
		sl_raddr   = '0;
		ls_we      = 1'b0;
		ls_waddr   = '0;
		ls_wdata   = '0;
		ls_re      = 1'b0;
		ls_raddr   = '0;
		dm_ctl     = '0;
		dm_rd_row  = '0;
		dm_wr_row  = '0;
		dm_wr_bits = '0;
		case (state_q)
			S_A1: begin
				if (!full && !no_label) begin
					if (dm_any) begin
						dm_ctl.rd_en = 1'b1;
						dm_rd_row    = dm_low_row;
					end else if (out_free) begin
						// append at the next unused slot
						sl_we    = 1'b1;
						sl_waddr = SAW'(used_q);
						sl_wdata = LW'(next_q);
						ls_we    = 1'b1;
						ls_waddr = LW'(next_q);
						ls_wdata = {1'b1, SXW'(used_q)};
					end
				end
			end
			S_A2: begin
				// clear the chosen bit and fetch the slot's old label
				sl_re        = 1'b1;
				sl_raddr     = SAW'(reuse_pick);
				dm_ctl.wr_en = 1'b1;
				dm_wr_row    = row_q;
				dm_wr_bits   = dm_rd_word & ~(ROW_BITS'(1) << dm_low_bit);
			end
			S_A3: begin
				// retire the old label, give the slot the new one
				ls_we    = 1'b1;
				ls_waddr = sl_rdata;
				ls_wdata = '0;
				sl_we    = 1'b1;
				sl_waddr = SAW'(pick_q);
				sl_wdata = LW'(next_q);
			end
			S_A4: begin
				if (out_free) begin
					ls_we    = 1'b1;
					ls_waddr = LW'(next_q);
					ls_wdata = {1'b1, pick_q};
				end
			end
			S_D1: begin
				if (!bad_label) begin
					ls_re    = 1'b1;
					ls_raddr = LW'(label_q);
				end
			end
			S_D2: begin
				if (ls_rdata[SXW]) begin
					dm_ctl.rd_en = 1'b1;
					dm_rd_row    = del_slot[SXW-1:BIT_W];
				end
			end
			S_D3: begin
				if (out_free && !dm_rd_word[del_bit]) begin
					dm_ctl.wr_en = 1'b1;
					dm_wr_row    = pick_q[SXW-1:BIT_W];
					dm_wr_bits   = dm_rd_word | (ROW_BITS'(1) << del_bit);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			label_q    <= '0;
			row_q      <= '0;
			pick_q     <= '0;
			used_q     <= '0;
			next_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// load a new result, or drop the one taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						label_q <= s_tdata[LABEL_W-1:0];
						state_q <= (kind_t'(s_tuser[0]) == KIND_DEL) ? S_D1 : S_A1;
					end
				end
				S_A1: begin
					if (!full && !no_label && dm_any) begin
						row_q   <= dm_low_row;
						state_q <= S_A2;
					end else if (out_free) begin
						state_q <= S_IDLE;
						if (full) begin
							m_tdata_q <= {M_PAD_W'(0), 1'b0, LABEL_W'(0), SLOT_W'(0), ST_FULL};
						end else if (no_label) begin
							m_tdata_q <= {M_PAD_W'(0), 1'b0, LABEL_W'(0), SLOT_W'(0),
								ST_NOLABEL};
						end else begin
							m_tdata_q <= {M_PAD_W'(0), 1'b0, LABEL_W'(next_q),
								SLOT_W'(used_q), ST_OK};
							used_q    <= used_q + UW'(1);
							next_q    <= next_q + NW'(1);
						end
					end
				end
				S_A2: begin
					pick_q  <= reuse_pick;
					state_q <= S_A3;
				end
				S_A3: begin
					state_q <= S_A4;
				end
				S_A4: begin
					if (out_free) begin
						m_tdata_q  <= {M_PAD_W'(0), 1'b1, LABEL_W'(next_q),
							SLOT_W'(pick_q), ST_OK};
						next_q     <= next_q + NW'(1);
						state_q    <= S_IDLE;
					end
				end
				S_D1: begin
					if (!bad_label) begin
						state_q <= S_D2;
					end else if (out_free) begin
						m_tdata_q  <= {M_PAD_W'(0), 1'b0, LABEL_W'(0), SLOT_W'(0),
							ST_BADLABEL};
						state_q    <= S_IDLE;
					end
				end
				S_D2: begin
					if (ls_rdata[SXW]) begin
						pick_q  <= del_slot;
						state_q <= S_D3;
					end else if (out_free) begin
						m_tdata_q  <= {M_PAD_W'(0), 1'b0, LABEL_W'(0), SLOT_W'(0),
							ST_BADLABEL};
						state_q    <= S_IDLE;
					end
				end
				S_D3: begin
					if (out_free) begin
						state_q    <= S_IDLE;
						if (dm_rd_word[del_bit]) begin
							m_tdata_q <= {M_PAD_W'(0), 1'b0, LABEL_W'(0), SLOT_W'(0),
								ST_BADLABEL};
						end else begin
							m_tdata_q <= {M_PAD_W'(0), 1'b0, LABEL_W'(0),
								SLOT_W'(pick_q), ST_OK};
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[sv/slra_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for every table of the allocator. No dependencies.
`timescale 1ns / 1ps

module slra_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                       wdata,
	input  logic                               re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                       rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	// write, and register read data when a read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/slra_delmap.sv]
// Two-level deleted-slot bitmap: a summary bit per row in flops, rows in RAM.
// A row whose summary bit is clear reads as zero, so reset needs no sweep.
// Depends on slra_pkg and slra_ram.
`timescale 1ns / 1ps

module slra_delmap #(
	parameter int ROWS = 32,
	parameter int RW   = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slra_pkg::dm_ctl_t             ctl,
	input  logic [RW-1:0]                 rd_row,
	input  logic [RW-1:0]                 wr_row,
	input  logic [slra_pkg::ROW_BITS-1:0] wr_bits,
	output logic                          any,
	output logic [RW-1:0]                 low_row,
	output logic [slra_pkg::ROW_BITS-1:0] rd_word,
	output logic [slra_pkg::BIT_W-1:0]    low_bit
);

	import slra_pkg::*;

	localparam int DEPTH = (ROWS < 2) ? 2 : ROWS;

	logic [ROWS-1:0]     sum_q;
	logic                sum_rd_q;
	logic [ROW_BITS-1:0] ram_rdata;

	// keep summary bits exact: set iff the row holds a deleted slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			sum_rd_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				sum_q[wr_row] <= |wr_bits;
			end
			if (ctl.rd_en) begin
				sum_rd_q <= sum_q[rd_row];
			end
		end
	end

	slra_ram #(
		.W (ROW_BITS),
		.D (DEPTH)
	) u_rows (
		.clk   (clk),
		.we    (ctl.wr_en),
		.waddr (wr_row),
		.wdata (wr_bits),
		.re    (ctl.rd_en),
		.raddr (rd_row),
		.rdata (ram_rdata)
	);

	// mask rows whose summary bit is clear, such as rows never written since reset
	assign rd_word = ram_rdata & {ROW_BITS{sum_rd_q}};
	assign any     = |sum_q;

	// lowest row with a deleted slot
	always_comb begin
		low_row = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (sum_q[i]) begin
				low_row = RW'(i);
			end
		end
	end

	// lowest deleted slot within the read row
	always_comb begin
		low_bit = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (rd_word[i]) begin
				low_bit = BIT_W'(i);
			end
		end
	end

endmodule
